// File: design/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, codes and the byte-wide CRC-16 update for the Modbus RTU
// frame CRC engine.
// ----------------------------------------------------------------------------
package mrc_pkg;

    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  EXC_MASK  = 8'h80;

    localparam logic DIR_TX = 1'b0;
    localparam logic DIR_RX = 1'b1;

    localparam logic KIND_TX = 1'b0;
    localparam logic KIND_RX = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_EXC     = 2'd2;

    localparam logic [1:0] POS_FUNC = 2'd1;
    localparam logic [1:0] POS_CODE = 2'd2;
    localparam logic [1:0] POS_SAT  = 2'd3;

    typedef struct packed {
        logic       direction;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic [7:0] exception_code;
        logic       run_end;
    } t_result;

    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_load;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: design/modbus_rtu_frame_crc_engine.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_crc_engine
// Modbus RTU frame streamer with reflected CRC-16 (poly 0xA001, seed 0xFFFF).
//
// Input channel (i_valid/o_ready): one frame byte per beat with its
// direction and a last-byte mark. Output channel (o_valid/i_ready): one
// result per beat. A transmit byte yields itself; a last transmit byte also
// yields CRC low then CRC high. A received byte yields nothing, except the
// last one, which yields a single status (ok, crc error or exception).
// o_run_end marks the final result of each input byte.
//
// An accepted byte passes the input register, then the result register,
// before its first result shows. Throughput: one byte per cycle while
// results are taken, set by the byte-wide CRC update between the input
// register and the three-entry result register; a last transmit byte holds
// it for three output beats. The input register takes one more beat while
// a result waits. Reset: CRC reloads 0xFFFF, byte position and captured
// bytes clear, both registers empty. When the receiver stalls, results
// hold and the input side stops once its register is full.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_crc_engine
    import mrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_direction,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic [7:0] o_exception_code,
    output logic       o_run_end
);

    t_item   in_item;
    t_item   held_item;
    logic    held;
    logic    can_load;
    logic    take;
    t_load   load;
    t_result res;

    assign in_item = '{direction: i_direction, data_byte: i_data_byte,
                       last_byte: i_last_byte};
    assign take    = held && can_load;

    mrc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_take  (take),
        .o_held  (held),
        .o_item  (held_item)
    );

    mrc_frame_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (held_item),
        .o_load  (load)
    );

    mrc_out_seq u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_en  (take),
        .i_load     (load),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (res)
    );

    assign o_kind           = res.kind;
    assign o_out_byte       = res.out_byte;
    assign o_status         = res.status;
    assign o_exception_code = res.exception_code;
    assign o_run_end        = res.run_end;

endmodule

// File: design/mrc_in_reg.sv
// ----------------------------------------------------------------------------
// mrc_in_reg
// Input register: holds one accepted beat until the frame core takes it.
// ----------------------------------------------------------------------------
module mrc_in_reg
    import mrc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_held,
    output t_item o_item
);

    logic  r_held;
    t_item r_item;

    assign o_ready = !r_held || i_take;
    assign o_held  = r_held;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (o_ready) begin
            r_held <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: design/mrc_frame_core.sv
// ----------------------------------------------------------------------------
// mrc_frame_core
// Frame state and CRC update; forms the results of one byte in one pass.
// ----------------------------------------------------------------------------
module mrc_frame_core
    import mrc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_item i_item,
    output t_load o_load
);

    logic [15:0] r_crc;
    logic [1:0]  r_pos;
    logic [7:0]  r_func;
    logic [7:0]  r_code;

    logic [15:0] n_crc;
    logic [1:0]  n_pos;
    logic [7:0]  n_func;
    logic [7:0]  n_code;
    logic [1:0]  st;
    logic [7:0]  ec;

    always_comb begin
        n_crc  = crc_byte(r_crc, i_item.data_byte);
        n_func = (r_pos == POS_FUNC) ? i_item.data_byte : r_func;
        n_code = (r_pos == POS_CODE) ? i_item.data_byte : r_code;
        n_pos  = (r_pos == POS_SAT) ? r_pos : r_pos + 2'd1;

        st = (n_crc == 16'h0000) ? ST_OK : ST_CRC_ERR;
        ec = 8'h00;
        if ((n_func & EXC_MASK) != 8'h00) begin
            st = ST_EXC;
            ec = n_code;
        end

        o_load = '0;
        if (i_item.direction == DIR_TX) begin
            o_load.res[0].kind     = KIND_TX;
            o_load.res[0].out_byte = i_item.data_byte;
            if (!i_item.last_byte) begin
                o_load.count          = 2'd1;
                o_load.res[0].run_end = 1'b1;
            end else begin
                o_load.count           = 2'd3;
                o_load.res[1].kind     = KIND_TX;
                o_load.res[1].out_byte = n_crc[7:0];
                o_load.res[2].kind     = KIND_TX;
                o_load.res[2].out_byte = n_crc[15:8];
                o_load.res[2].run_end  = 1'b1;
            end
        end else if (i_item.last_byte) begin
            o_load.count                = 2'd1;
            o_load.res[0].kind          = KIND_RX;
            o_load.res[0].status        = st;
            o_load.res[0].exception_code = ec;
            o_load.res[0].run_end       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= CRC_START;
            r_pos  <= 2'd0;
            r_func <= 8'h00;
            r_code <= 8'h00;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                r_crc  <= CRC_START;
                r_pos  <= 2'd0;
                r_func <= 8'h00;
                r_code <= 8'h00;
            end else begin
                r_crc  <= n_crc;
                r_pos  <= n_pos;
                r_func <= n_func;
                r_code <= n_code;
            end
        end
    end

endmodule

// File: design/mrc_out_seq.sv
// ----------------------------------------------------------------------------
// mrc_out_seq
// Result register: holds up to three results and shifts them out in order.
// ----------------------------------------------------------------------------
module mrc_out_seq
    import mrc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load_en,
    input  t_load   i_load,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic [1:0]    r_cnt;
    t_result [2:0] r_res;
    logic          pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_res      = r_res[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load_en) begin
            r_cnt <= i_load.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_res <= i_load.res;
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

endmodule

// File: design/mrc_checker.sv
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mrc_checker
    import mrc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_kind,
    input logic [7:0] o_out_byte,
    input logic [1:0] o_status,
    input logic [7:0] o_exception_code,
    input logic       o_run_end
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_out_byte)
            && $stable(o_status) && $stable(o_exception_code) && $stable(o_run_end))
        else $error("result beat changed while stalled");

    a_rx_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_RX |-> o_run_end && o_out_byte == 8'h00)
        else $error("receive status is not a lone final result");

    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_TX |-> o_status == ST_OK && o_exception_code == 8'h00)
        else $error("transmit beat carries status fields");

    a_exc_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_EXC |-> o_exception_code == 8'h00)
        else $error("exception code without exception status");

endmodule

bind modbus_rtu_frame_crc_engine mrc_checker u_mrc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_kind           (o_kind),
    .o_out_byte       (o_out_byte),
    .o_status         (o_status),
    .o_exception_code (o_exception_code),
    .o_run_end        (o_run_end)
);

// File: verif/mrc_frame_checker.sv
// ----------------------------------------------------------------------------
// mrc_frame_checker
// Watches both channels of the Modbus RTU frame CRC engine, keeps its own
// running CRC, byte position and captured function/code bytes, builds the
// results each accepted byte should cause and compares every output beat,
// field by field, with the oldest of them.
// ----------------------------------------------------------------------------
module mrc_frame_checker
    import mrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_direction,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_kind,
    input  logic [7:0] i_out_byte,
    input  logic [1:0] i_status,
    input  logic [7:0] i_exception_code,
    input  logic       i_run_end,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] crc_run;
    logic [1:0]  frame_pos;
    logic [7:0]  func_seen;
    logic [7:0]  code_seen;
    t_result     result_q[$];
    int          mismatches = 0;
    int          pending_n = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;

    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[15:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic clear_frame();
        crc_run   = CRC_START;
        frame_pos = 2'd0;
        func_seen = 8'h00;
        code_seen = 8'h00;
    endtask

    task automatic predict_beat(input logic dir, input logic [7:0] b, input logic fin);
        logic [15:0] c;
        t_result     r;
        if (frame_pos == POS_FUNC) begin
            func_seen = b;
        end else if (frame_pos == POS_CODE) begin
            code_seen = b;
        end
        if (frame_pos != POS_SAT) begin
            frame_pos = frame_pos + 2'd1;
        end
        c       = crc16_next(crc_run, b);
        crc_run = c;
        r.status         = ST_OK;
        r.exception_code = 8'h00;
        if (dir == DIR_TX) begin
            r.kind     = KIND_TX;
            r.out_byte = b;
            r.run_end  = !fin;
            result_q.push_back(r);
            if (fin) begin
                r.out_byte = c[7:0];
                result_q.push_back(r);
                r.out_byte = c[15:8];
                r.run_end  = 1'b1;
                result_q.push_back(r);
            end
        end else if (fin) begin
            r.kind     = KIND_RX;
            r.out_byte = 8'h00;
            r.run_end  = 1'b1;
            r.status   = (c == 16'h0000) ? ST_OK : ST_CRC_ERR;
            if ((func_seen & EXC_MASK) != 8'h00) begin
                r.status         = ST_EXC;
                r.exception_code = code_seen;
            end
            result_q.push_back(r);
        end
        if (fin) begin
            clear_frame();
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_frame();
            result_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    report($sformatf("unexpected beat kind %0d byte 0x%02h status %0d",
                                     i_kind, i_out_byte, i_status));
                end else begin
                    want = result_q.pop_front();
                    if (i_kind !== want.kind)
                        report($sformatf("kind got %0d expected %0d", i_kind, want.kind));
                    if (i_out_byte !== want.out_byte)
                        report($sformatf("out_byte got 0x%02h expected 0x%02h",
                                         i_out_byte, want.out_byte));
                    if (i_status !== want.status)
                        report($sformatf("status got %0d expected %0d",
                                         i_status, want.status));
                    if (i_exception_code !== want.exception_code)
                        report($sformatf("exception_code got 0x%02h expected 0x%02h",
                                         i_exception_code, want.exception_code));
                    if (i_run_end !== want.run_end)
                        report($sformatf("run_end got %0d expected %0d",
                                         i_run_end, want.run_end));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_beat(i_direction, i_data_byte, i_last_byte);
            end
        end
        pending_n = result_q.size();
    end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives Modbus RTU frame bytes into the CRC engine: a directed set of
// transmit, receive, exception, short and mixed-direction frames, then
// random well-formed, corrupted, transmit and noise frames, with random
// gaps on both channels. Prediction and checking live in the checker.
// ----------------------------------------------------------------------------
module testbench;
    import mrc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 75;
    localparam int CALM_FROM      = 80;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int TAIL_CYCLES    = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic       i_direction;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_ready;
    logic       o_kind;
    logic [7:0] o_out_byte;
    logic [1:0] o_status;
    logic [7:0] o_exception_code;
    logic       o_run_end;

    int         fail_count;
    int         pending;
    int         sent = 0;
    bit         calm = 1'b0;
    logic [7:0] frame_q[$];

    modbus_rtu_frame_crc_engine u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_direction      (i_direction),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_out_byte       (o_out_byte),
        .o_status         (o_status),
        .o_exception_code (o_exception_code),
        .o_run_end        (o_run_end)
    );

    mrc_frame_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_direction      (i_direction),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_kind           (o_kind),
        .i_out_byte       (o_out_byte),
        .i_status         (o_status),
        .i_exception_code (o_exception_code),
        .i_run_end        (o_run_end),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [15:0] frame_crc(input logic [7:0] bytes[$]);
        logic [15:0] c;
        c = CRC_START;
        foreach (bytes[i]) begin
            c = c ^ {8'h00, bytes[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic append_crc();
        logic [15:0] c;
        c = frame_crc(frame_q);
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endtask

    task automatic send_beat(input logic dir, input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_direction = dir;
        i_data_byte = b;
        i_last_byte = fin;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        if (sent >= CALM_FROM) calm = 1'b1;
    endtask

    task automatic send_frame(input logic dir);
        foreach (frame_q[i]) begin
            send_beat(dir, frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic fill_body(input int n, input bit exc);
        logic [7:0] b;
        frame_q.delete();
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (i == 1) b[7] = exc;
            frame_q.push_back(b);
        end
    endtask

    initial begin
        int hold;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                hold    = $urandom_range(1, 4);
                repeat (hold - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    initial begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int pick;
        int n;
        int idx;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_direction = DIR_TX;
        i_data_byte = 8'h00;
        i_last_byte = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        frame_q = '{8'h00, 8'hFF, 8'h80};
        send_frame(DIR_TX);
        frame_q = '{8'hFF};
        send_frame(DIR_TX);
        frame_q = '{8'h11, 8'h03, 8'h00, 8'h6B};
        append_crc();
        send_frame(DIR_RX);
        frame_q = '{8'h11, 8'h06, 8'h55};
        send_frame(DIR_RX);
        frame_q = '{8'h01, 8'h83, 8'h02};
        append_crc();
        send_frame(DIR_RX);
        frame_q = '{8'hFF};
        send_frame(DIR_RX);
        frame_q = '{8'h01, 8'h81};
        send_frame(DIR_RX);
        send_beat(DIR_TX, 8'h05, 1'b0);
        send_beat(DIR_RX, 8'hAA, 1'b1);
        send_beat(DIR_RX, 8'h05, 1'b0);
        send_beat(DIR_TX, 8'h90, 1'b1);
        drain();

        while (sent < RANDOM_ITEMS + 25) begin
            pick = $urandom_range(0, 99);
            n    = $urandom_range(1, 8);
            if (pick < 5) drain();
            if (pick < 55) begin
                fill_body(n, $urandom_range(0, 3) == 0);
                append_crc();
                if (pick >= 45) begin
                    idx = $urandom_range(0, frame_q.size() - 1);
                    frame_q[idx][$urandom_range(0, 7)] ^= 1'b1;
                end
                send_frame(DIR_RX);
            end else if (pick < 90) begin
                fill_body(n, 1'($urandom_range(0, 1)));
                send_frame(DIR_TX);
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) begin
                    send_beat(1'($urandom_range(0, 1)), 8'($urandom), k == n - 1);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
